// ===== hw/rtl/ini_line_tokenizer_top_assert.svh =====
// assertion macros used by the tokenizer port checker
`ifndef INI_LINE_TOKENIZER_TOP_ASSERT_SVH
`define INI_LINE_TOKENIZER_TOP_ASSERT_SVH

// implication checked in the same cycle, off while reset is held
`define ILT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ilt check failed");

// implication checked in the next cycle, off while reset is held
`define ILT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ilt check failed");

// implication checked in the next cycle, reset included
`define ILT_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ilt check failed");

`endif

// ===== hw/rtl/ilt_pkg.sv =====
// shared types, constants and helpers for the ini line tokenizer
package ilt_pkg;

    // token buffer size and the fill limit that follows from it
    localparam int BUFFER_SIZE  = 4096;
    localparam int FILL_W       = 12;
    localparam int FILL_LIMIT_I = (BUFFER_SIZE - 1 > 4095) ? 4095 : BUFFER_SIZE - 1;
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(FILL_LIMIT_I);

    // characters the parser reacts to
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // item kinds on the input side
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // event codes on the output side
    typedef enum logic [2:0] {
        EV_SEC_START = 3'd0,
        EV_SEC_CHAR  = 3'd1,
        EV_SEC_END   = 3'd2,
        EV_KEY_CHAR  = 3'd3,
        EV_KEY_END   = 3'd4,
        EV_KEY_ABORT = 3'd5,
        EV_VAL_CHAR  = 3'd6,
        EV_VAL_END   = 3'd7
    } t_event_code;

    // one input item held in the input register
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    // one result item
    typedef struct packed {
        t_event_code       code;
        logic [7:0]        ch;
        logic [FILL_W-1:0] len;
    } t_event;

    // continuation bytes that follow a utf-8 lead byte
    function automatic logic [2:0] utf8_tail(input logic [7:0] c);
        logic [2:0] k;
        k = 3'd0;
        if (c >= 8'hC0 && c <= 8'hDF) k = 3'd1;
        else if (c >= 8'hE0 && c <= 8'hEF) k = 3'd2;
        else if (c >= 8'hF0 && c <= 8'hF7) k = 3'd3;
        else if (c >= 8'hF8 && c <= 8'hFB) k = 3'd4;
        else if (c >= 8'hFC && c <= 8'hFD) k = 3'd5;
        return k;
    endfunction

endpackage

// ===== hw/rtl/ini_line_tokenizer_top.sv =====
// top level of the ini line tokenizer
//
// Input channel s_*: one item per byte of the file. s_tdata carries the byte,
// s_tuser marks the item as data (0) or end of stream (1).
// Output channel m_*: one item per token event. m_tuser carries the event code,
// m_tdata carries the event's character and the finished token's length.
// A byte causes at most one event; many bytes (blanks, comments, carriage
// returns) cause none and leave nothing on the output.
// Path: an accepted byte waits in the input register, and its event is loaded
// into the output register (the state machine runs between the two).
// Throughput: one item per cycle while the output register has room, set by
// the state update between the input register and the output register.
// When m_tready is low the event waits in the output register; the input
// register still takes one more item, and s_tready drops only once that item
// needs the full output register. Items that cause no event pass on regardless.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the state before the first section header with counts cleared.
// End of stream closes any open token and also returns the parser to that state.
module ini_line_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_req
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] char_out, [19:8] token_length, [23:20] zero
    output logic [2:0]  m_tuser    // [2:0] event_res
);
    import ilt_pkg::*;

    t_item  in_item, held_item;
    t_event ev, out_ev;
    logic   held_valid, adv, ev_load, out_free;

    assign in_item.kind      = s_tuser;
    assign in_item.data_byte = s_tdata;

    // input register
    ilt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (in_item),
        .i_adv   (adv),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // state machine
    ilt_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_item     (held_item),
        .i_out_free (out_free),
        .o_adv      (adv),
        .o_ev_load  (ev_load),
        .o_ev       (ev)
    );

    // output register
    ilt_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ev_load),
        .i_ev    (ev),
        .o_free  (out_free),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_ev    (out_ev)
    );

    // pack the output item
    assign m_tuser = out_ev.code;
    assign m_tdata = {4'h0, out_ev.len, out_ev.ch};

endmodule

// ===== hw/rtl/ilt_in_stage.sv =====
// input register that holds one item for the parser
module ilt_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ilt_pkg::t_item i_item,
    input  logic          i_adv,
    output logic          o_valid,
    output ilt_pkg::t_item o_item
);
    import ilt_pkg::*;

    logic  r_valid;
    t_item r_item;

    // free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_adv;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/ilt_parser.sv =====
// tokenizer state machine: one item in, at most one event out
module ilt_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ilt_pkg::t_item  i_item,
    input  logic            i_out_free,
    output logic            o_adv,
    output logic            o_ev_load,
    output ilt_pkg::t_event o_ev
);
    import ilt_pkg::*;

    typedef enum logic [2:0] {
        ST_FIRST      = 3'd0,
        ST_SECHDR     = 3'd1,
        ST_SKIP       = 3'd2,
        ST_SKIP_FIRST = 3'd3,
        ST_KEYDEF     = 3'd4,
        ST_ONKEY      = 3'd5,
        ST_VALUE      = 3'd6,
        ST_WIDE       = 3'd7
    } t_state;

    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill, fill_inc;
    logic [2:0]        r_rem, n_rem, tail;
    logic              full, ev_valid;
    t_event            ev;
    logic [7:0]        c;

    assign c        = i_item.data_byte;
    assign full     = r_fill >= FILL_LIMIT;
    assign fill_inc = full ? r_fill : r_fill + 1'b1;
    assign tail     = utf8_tail(c);

    // next state and event for the held item
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_rem    = r_rem;
        ev_valid = 1'b0;
        ev.code  = EV_SEC_START;
        ev.ch    = 8'h00;
        ev.len   = '0;
        if (i_item.kind == KIND_EOS) begin
            // close whatever is open, then back to reset values
            if (r_state == ST_VALUE || r_state == ST_WIDE) begin
                ev_valid = 1'b1;
                ev.code  = EV_VAL_END;
                ev.len   = r_fill;
            end else if (r_state == ST_ONKEY) begin
                ev_valid = 1'b1;
                ev.code  = EV_KEY_ABORT;
            end else if (r_state == ST_SECHDR) begin
                ev_valid = 1'b1;
                ev.code  = EV_SEC_END;
                ev.len   = r_fill;
            end
            n_state = ST_FIRST;
            n_fill  = '0;
            n_rem   = 3'd0;
        end else if (c == CH_CR && r_state != ST_WIDE) begin
            // carriage return dropped
        end else begin
            unique case (r_state)
                ST_SECHDR: begin
                    ev_valid = 1'b1;
                    if (c == CH_RBRK || full) begin
                        ev.code = EV_SEC_END;
                        ev.len  = r_fill;
                        n_fill  = '0;
                        n_state = ST_SKIP;
                    end else begin
                        ev.code = EV_SEC_CHAR;
                        ev.ch   = c;
                        n_fill  = fill_inc;
                    end
                end
                ST_SKIP, ST_SKIP_FIRST: begin
                    if (c == CH_LF) begin
                        n_state = (r_state == ST_SKIP_FIRST) ? ST_FIRST : ST_KEYDEF;
                        n_fill  = '0;
                    end
                end
                ST_FIRST, ST_KEYDEF, ST_ONKEY: begin
                    if (c == CH_HASH) begin
                        // comment, a partial key is thrown away
                        if (r_state == ST_ONKEY) begin
                            ev_valid = 1'b1;
                            ev.code  = EV_KEY_ABORT;
                        end
                        n_state = (r_state == ST_FIRST) ? ST_SKIP_FIRST : ST_SKIP;
                    end else if (c == CH_LBRK && r_state != ST_ONKEY) begin
                        ev_valid = 1'b1;
                        ev.code  = EV_SEC_START;
                        n_state  = ST_SECHDR;
                        n_fill   = '0;
                    end else if (r_state == ST_FIRST) begin
                        // nothing before the first section counts
                    end else if ((c == CH_SPACE && r_state != ST_ONKEY) || c == CH_TAB) begin
                        // blanks before a key and tabs anywhere in it are dropped
                    end else if (c == CH_LF || full) begin
                        if (r_state == ST_ONKEY) begin
                            ev_valid = 1'b1;
                            ev.code  = EV_KEY_ABORT;
                        end
                        n_fill  = '0;
                        n_state = ST_KEYDEF;
                    end else if (c == CH_EQ) begin
                        ev_valid = 1'b1;
                        ev.code  = EV_KEY_END;
                        ev.len   = r_fill;
                        n_fill   = '0;
                        n_state  = ST_VALUE;
                    end else begin
                        ev_valid = 1'b1;
                        ev.code  = EV_KEY_CHAR;
                        ev.ch    = c;
                        n_fill   = fill_inc;
                        n_state  = ST_ONKEY;
                    end
                end
                ST_VALUE: begin
                    ev_valid = 1'b1;
                    if (full || c == CH_LF) begin
                        ev.code = EV_VAL_END;
                        ev.len  = r_fill;
                        n_state = (c == CH_LF) ? ST_KEYDEF : ST_SKIP;
                        n_fill  = '0;
                    end else begin
                        if (tail != 3'd0) begin
                            n_state = ST_WIDE;
                            n_rem   = tail;
                        end
                        ev.code = EV_VAL_CHAR;
                        ev.ch   = c;
                        n_fill  = fill_inc;
                    end
                end
                ST_WIDE: begin
                    // every byte of a utf-8 run is value text
                    n_rem = (r_rem != 3'd0) ? r_rem - 3'd1 : r_rem;
                    if (n_rem == 3'd0) begin
                        n_state = ST_VALUE;
                    end
                    ev_valid = 1'b1;
                    ev.code  = EV_VAL_CHAR;
                    ev.ch    = c;
                    n_fill   = fill_inc;
                end
                default: begin
                    n_state = ST_FIRST;
                end
            endcase
        end
    end

    // the item moves on unless its event finds the output register full
    assign o_adv     = i_valid && (!ev_valid || i_out_free);
    assign o_ev_load = o_adv && ev_valid;
    assign o_ev      = ev;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FIRST;
            r_fill  <= '0;
            r_rem   <= 3'd0;
        end else if (o_adv) begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rem   <= n_rem;
        end
    end

endmodule

// ===== hw/rtl/ilt_out_stage.sv =====
// output register that holds one event until the receiver takes it
module ilt_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ilt_pkg::t_event i_ev,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output ilt_pkg::t_event o_ev
);
    import ilt_pkg::*;

    logic   r_valid;
    t_event r_ev;

    // room for a new event when empty or being drained
    assign o_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev <= i_ev;
        end
    end

    assign o_valid = r_valid;
    assign o_ev    = r_ev;

endmodule

// ===== hw/rtl/ilt_checker.sv =====
// port-level checks for the ini line tokenizer, bound to the top level
`include "ini_line_tokenizer_top_assert.svh"

module ilt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import ilt_pkg::*;

    logic is_char;

    assign is_char = (m_tuser == EV_SEC_CHAR) || (m_tuser == EV_KEY_CHAR)
                  || (m_tuser == EV_VAL_CHAR);

    // a stalled item holds its contents
    `ILT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // character events carry no length, the others carry no character
    `ILT_ASSERT_SAME(a_char_len, i_clk, i_rst_n, m_tvalid && is_char, m_tdata[19:8] == 12'h000)
    `ILT_ASSERT_SAME(a_end_char, i_clk, i_rst_n, m_tvalid && !is_char, m_tdata[7:0] == 8'h00 && m_tdata[23:20] == 4'h0)

    // reset empties the output register
    `ILT_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_tvalid)

endmodule

bind ini_line_tokenizer_top ilt_checker u_ilt_checker (.*);

// ===== bench/ilt_event_checker.sv =====
// event checker for the ini line tokenizer: predicts token events and compares them
module ilt_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_req
    input  logic        i_s_tuser,   // [0] kind
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] char_out, [19:8] token_length, [23:20] zero
    input  logic [2:0]  i_m_tuser,   // [2:0] event_res
    output int          o_fail_count,
    output int          o_pending
);
    import ilt_pkg::*;

    // parser position as the predictor tracks it
    typedef enum logic [2:0] {
        PS_FIRST,
        PS_SECHDR,
        PS_SKIP,
        PS_SKIP_FIRST,
        PS_KEYDEF,
        PS_ONKEY,
        PS_VALUE,
        PS_WIDE
    } t_parse_state;

    t_parse_state      ps;
    logic [FILL_W-1:0] fill;
    logic [2:0]        utf8_left;
    t_event            tokens_due[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < 200)
            $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic queue_event(input t_event_code code, input logic [7:0] ch,
                               input logic [FILL_W-1:0] len);
        tokens_due.push_back(t_event'{code: code, ch: ch, len: len});
    endtask

    task automatic clear_parser();
        ps = PS_FIRST;
        fill = '0;
        utf8_left = '0;
    endtask

    // fill count saturates at the limit
    task automatic bump_fill();
        if (fill < FILL_LIMIT)
            fill = fill + 1'b1;
    endtask

    // continuation bytes announced by a utf-8 lead byte
    function automatic logic [2:0] utf8_extra(input logic [7:0] c);
        if (c[7:6] != 2'b11)
            return 3'd0;
        casez (c[5:0])
            6'b0?????: return 3'd1;
            6'b10????: return 3'd2;
            6'b110???: return 3'd3;
            6'b1110??: return 3'd4;
            6'b11110?: return 3'd5;
            default:   return 3'd0;
        endcase
    endfunction

    // advance the predicted parser by one item
    task automatic tokenize_byte(input logic kind, input logic [7:0] c);
        logic              full;
        logic [FILL_W-1:0] len;
        logic [2:0]        extra;
        full = (fill >= FILL_LIMIT);
        len = fill;
        if (kind == KIND_EOS) begin
            case (ps)
                PS_VALUE, PS_WIDE: queue_event(EV_VAL_END, 8'h00, len);
                PS_ONKEY:          queue_event(EV_KEY_ABORT, 8'h00, '0);
                PS_SECHDR:         queue_event(EV_SEC_END, 8'h00, len);
                default: ;
            endcase
            clear_parser();
        end else if (!(c == CH_CR && ps != PS_WIDE)) begin
            case (ps)
                PS_SECHDR: begin
                    if (c == CH_RBRK || full) begin
                        queue_event(EV_SEC_END, 8'h00, len);
                        fill = '0;
                        ps = PS_SKIP;
                    end else begin
                        queue_event(EV_SEC_CHAR, c, '0);
                        bump_fill();
                    end
                end
                PS_SKIP, PS_SKIP_FIRST: begin
                    if (c == CH_LF) begin
                        ps = (ps == PS_SKIP_FIRST) ? PS_FIRST : PS_KEYDEF;
                        fill = '0;
                    end
                end
                PS_FIRST, PS_KEYDEF, PS_ONKEY: begin
                    if (c == CH_HASH) begin
                        if (ps == PS_ONKEY)
                            queue_event(EV_KEY_ABORT, 8'h00, '0);
                        ps = (ps == PS_FIRST) ? PS_SKIP_FIRST : PS_SKIP;
                    end else if (c == CH_LBRK && ps != PS_ONKEY) begin
                        queue_event(EV_SEC_START, 8'h00, '0);
                        ps = PS_SECHDR;
                        fill = '0;
                    end else if (ps == PS_FIRST) begin
                        // nothing counts before the first section header
                    end else if ((c == CH_SPACE && ps != PS_ONKEY) || c == CH_TAB) begin
                        // blanks before a key and tabs anywhere in it are dropped
                    end else if (c == CH_LF || full) begin
                        if (ps == PS_ONKEY)
                            queue_event(EV_KEY_ABORT, 8'h00, '0);
                        fill = '0;
                        ps = PS_KEYDEF;
                    end else if (c == CH_EQ) begin
                        queue_event(EV_KEY_END, 8'h00, len);
                        fill = '0;
                        ps = PS_VALUE;
                    end else begin
                        queue_event(EV_KEY_CHAR, c, '0);
                        bump_fill();
                        ps = PS_ONKEY;
                    end
                end
                PS_VALUE: begin
                    if (full || c == CH_LF) begin
                        queue_event(EV_VAL_END, 8'h00, len);
                        ps = (c == CH_LF) ? PS_KEYDEF : PS_SKIP;
                        fill = '0;
                    end else begin
                        extra = utf8_extra(c);
                        if (extra != 3'd0) begin
                            ps = PS_WIDE;
                            utf8_left = extra;
                        end
                        queue_event(EV_VAL_CHAR, c, '0);
                        bump_fill();
                    end
                end
                default: begin
                    // inside a multibyte run every byte is value text
                    if (utf8_left != 3'd0)
                        utf8_left = utf8_left - 3'd1;
                    if (utf8_left == 3'd0)
                        ps = PS_VALUE;
                    queue_event(EV_VAL_CHAR, c, '0);
                    bump_fill();
                end
            endcase
        end
    endtask

    // outputs are compared before the same edge's input is predicted
    always @(posedge i_clk) begin : watch
        t_event want;
        if (!i_rst_n) begin
            clear_parser();
            tokens_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (tokens_due.size() == 0) begin
                    report_mismatch($sformatf("event %0d with nothing pending", i_m_tuser));
                end else begin
                    want = tokens_due.pop_front();
                    if (i_m_tuser !== want.code)
                        report_mismatch($sformatf("event code %0d, wanted %0d",
                                                  i_m_tuser, want.code));
                    if (i_m_tdata[7:0] !== want.ch)
                        report_mismatch($sformatf("char %02h, wanted %02h",
                                                  i_m_tdata[7:0], want.ch));
                    if (i_m_tdata[19:8] !== want.len)
                        report_mismatch($sformatf("length %0d, wanted %0d",
                                                  i_m_tdata[19:8], want.len));
                end
            end
            if (i_s_tvalid && i_s_tready)
                tokenize_byte(i_s_tuser, i_s_tdata);
        end
        o_pending = tokens_due.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the ini line tokenizer: file stimulus, flow control and verdict
module tb_top;
    import ilt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] byte_req
    logic        s_tuser;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;    // [7:0] char_out, [19:8] token_length, [23:20] zero
    logic [2:0]  m_tuser;    // [2:0] event_res

    int     src_idle_pct = 0;
    int     snk_stall_pct = 0;
    int     hold_id = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     fail_count;
    int     pending_count;
    int     planned = 0;
    bit     in_file = 1'b0;
    t_item  file_bytes[$];

    // opening bytes: blanks, comments, brackets, utf-8 runs and aborted keys
    logic [7:0] opening_text [0:24] = '{
        8'h61, CH_HASH, 8'h78, CH_LF,
        CH_LBRK, 8'h00, 8'hFF, CH_CR, CH_RBRK, CH_LF,
        CH_TAB, 8'h6B, CH_SPACE, CH_EQ, 8'hE2, CH_CR, CH_LF, CH_LF,
        8'h7A, CH_HASH, CH_LF, 8'h71, CH_LF, CH_EQ, 8'hFD
    };

    ini_line_tokenizer_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ilt_event_checker u_event_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_seen != hold_id) begin
            hold_seen <= hold_id;
            hold_left <= 300;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(126, 33));
        while (c == CH_HASH || c == CH_EQ || c == CH_LBRK || c == CH_RBRK);
        return c;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] utf8_lead(input int extra);
        case (extra)
            1:       return 8'($urandom_range(8'hDF, 8'hC0));
            2:       return 8'($urandom_range(8'hEF, 8'hE0));
            3:       return 8'($urandom_range(8'hF7, 8'hF0));
            4:       return 8'($urandom_range(8'hFB, 8'hF8));
            default: return 8'($urandom_range(8'hFD, 8'hFC));
        endcase
    endfunction

    // continuation byte, now and then a line break that the run swallows
    function automatic logic [7:0] cont_byte();
        case ($urandom_range(15))
            0:       return CH_LF;
            1:       return CH_CR;
            default: return 8'($urandom_range(8'hBF, 8'h80));
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        file_bytes.push_back(t_item'{kind: KIND_DATA, data_byte: b});
        planned++;
    endtask

    task automatic push_eos();
        file_bytes.push_back(t_item'{kind: KIND_EOS, data_byte: 8'($urandom_range(255))});
        planned++;
        in_file = 1'b0;
    endtask

    task automatic push_blanks(input int n);
        repeat (n) push_byte($urandom_range(1) ? CH_TAB : CH_SPACE);
    endtask

    task automatic push_key(input int n);
        push_blanks($urandom_range(2));
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(9) == 0)
                push_byte($urandom_range(1) ? CH_TAB : CH_SPACE);
            push_byte(name_char());
        end
    endtask

    task automatic push_value(input int n);
        int r;
        int extra;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                push_byte(8'($urandom_range(126, 32)));
            end else if (r < 85) begin
                extra = $urandom_range(5, 1);
                push_byte(utf8_lead(extra));
                repeat (extra) push_byte(cont_byte());
            end else begin
                push_byte(any_but_lf());
            end
        end
    endtask

    task automatic push_section(input int n);
        push_byte(CH_LBRK);
        repeat (n) begin
            if ($urandom_range(7) == 0)
                push_byte(8'($urandom_range(255)) == CH_RBRK ? CH_SPACE : any_but_lf());
            else
                push_byte(name_char());
        end
        push_byte(CH_RBRK);
        repeat ($urandom_range(2)) push_byte(name_char());
        push_byte(CH_LF);
        in_file = 1'b1;
    endtask

    task automatic push_comment();
        push_blanks($urandom_range(2));
        push_byte(CH_HASH);
        repeat ($urandom_range(10)) push_byte(any_but_lf());
        push_byte(CH_LF);
    endtask

    // one random line of a desktop entry file, well formed most of the time
    task automatic push_line();
        int r;
        if (!in_file) begin
            if ($urandom_range(1))
                push_comment();
            push_section($urandom_range(10));
        end
        r = $urandom_range(99);
        if (r < 12) begin
            push_section($urandom_range(10));
        end else if (r < 60) begin
            push_key($urandom_range(12, 1));
            push_byte(CH_EQ);
            push_value($urandom_range(20));
            if ($urandom_range(3) == 0)
                push_byte(CH_CR);
            push_byte(CH_LF);
        end else if (r < 68) begin
            push_comment();
        end else if (r < 73) begin
            push_blanks($urandom_range(3));
            if ($urandom_range(1))
                push_byte(CH_CR);
            push_byte(CH_LF);
        end else if (r < 80) begin
            // key cut off by a line break or a comment
            push_key($urandom_range(6, 1));
            if ($urandom_range(1)) begin
                push_byte(CH_HASH);
                repeat ($urandom_range(4)) push_byte(name_char());
            end
            push_byte(CH_LF);
        end else if (r < 85) begin
            // bracket inside a key name is plain key text
            push_key($urandom_range(3, 1));
            push_byte(CH_LBRK);
            push_key($urandom_range(3));
            push_byte(CH_EQ);
            push_value($urandom_range(6));
            push_byte(CH_LF);
        end else if (r < 90) begin
            repeat ($urandom_range(8, 1)) push_byte(8'($urandom_range(255)));
        end else if (r < 95) begin
            // stream ends with a token still open
            case ($urandom_range(2))
                0: begin
                    push_byte(CH_LBRK);
                    repeat ($urandom_range(4)) push_byte(name_char());
                end
                1: push_key($urandom_range(5, 1));
                default: begin
                    push_key($urandom_range(5, 1));
                    push_byte(CH_EQ);
                    push_value($urandom_range(6));
                    if ($urandom_range(1))
                        push_byte(utf8_lead($urandom_range(5, 1)));
                end
            endcase
            push_eos();
        end else begin
            push_eos();
        end
    endtask

    // one item per handshake, with random gaps between items
    task automatic send_item(input t_item it);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= it.data_byte;
        do @(posedge i_clk);
        while (!s_tready);
    endtask

    task automatic send_plan();
        while (file_bytes.size() != 0)
            send_item(file_bytes.pop_front());
    endtask

    initial begin
        int goal;
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tuser <= KIND_DATA;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening, closed by end of stream inside a utf-8 run
        foreach (opening_text[i])
            push_byte(opening_text[i]);
        push_eos();
        send_plan();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct <= 0;
                    snk_stall_pct <= 0;
                end
                1: begin
                    src_idle_pct <= 66;
                    snk_stall_pct <= 0;
                end
                2: begin
                    src_idle_pct <= 0;
                    snk_stall_pct <= 66;
                end
                default: begin
                    src_idle_pct <= 8;
                    snk_stall_pct <= 8;
                end
            endcase
            if (ph == 0) begin
                // receiver holds off while the sender keeps offering
                hold_id <= hold_id + 1;
            end
            goal = planned + 300;
            while (planned < goal) begin
                push_line();
                send_plan();
            end
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
